// File: rtl/buddy_page_allocator_assert.svh
// Assertion macros used by the checker file of the buddy page allocator.
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define BPA_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("buddy page allocator check failed");

// Next-cycle implication, disabled while reset is high.
`define BPA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("buddy page allocator check failed");

// Next-cycle implication that is also checked across reset.
`define BPA_ASSERT_AFTER_RESET(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("buddy page allocator check failed after reset");

`endif

// File: rtl/bpa_pkg.sv
package bpa_pkg;

   localparam int PAGES_W  = 9;
   localparam int OFFSET_W = 8;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
   localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

   typedef struct packed {
      logic                func;
      logic [PAGES_W-1:0]  req_pages;
      logic [OFFSET_W-1:0] free_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [OFFSET_W-1:0] page_offset;
   } rsp_type;

endpackage

// File: rtl/buddy_page_allocator.sv
// Channel   Ports                              Direction  Moves
// request   req_valid, req_ready, req_data     in         one alloc or free per transfer
// response  rsp_valid, rsp_ready, rsp_data     out        one status per request
//
// After reset the tree memory is written one node a cycle, all 2*POOL-1 nodes
// (511 for 256 pages), with req_ready low. POOL is the largest power of two
// not above UNITS. An alloc descends from the root and a free climbs from its
// leaf, each step through the single read and write port of the tree memory.
// One request is in flight at a time; a held response lets the next request
// transfer, which then waits in its last state.
module buddy_page_allocator #(
   parameter int UNITS = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bpa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bpa_pkg::rsp_type rsp_data
);

   localparam int LEVELS  = $clog2(UNITS + 1) - 1;
   localparam int POOL    = 1 << LEVELS;
   localparam int TREE_N  = 2 * POOL - 1;
   localparam int VAL_W   = LEVELS + 1;
   localparam int IDX_W   = LEVELS + 1;
   localparam int OFF_W   = LEVELS;
   localparam int PG_W    = bpa_pkg::PAGES_W;
   localparam int PO_W    = bpa_pkg::OFFSET_W;
   localparam int CMP_W   = (VAL_W > PG_W + 1) ? VAL_W : PG_W + 1;

   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_ROOT  = 9'b000000100,
      S_RIGHT = 9'b000001000,
      S_PICK  = 9'b000010000,
      S_MARK  = 9'b000100000,
      S_CLIMB = 9'b001000000,
      S_UP    = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   function automatic logic [PG_W:0] round_pow2(input logic [PG_W-1:0] w);
      logic [PG_W-1:0] m;
      m = w - PG_W'(1);
      for (int s = 1; s < PG_W; s = s * 2) begin
         m = m | (m >> s);
      end
      return {1'b0, m} + (PG_W + 1)'(1);
   endfunction

   function automatic logic [IDX_W-1:0] sibling(input logic [IDX_W-1:0] n);
      return n[0] ? n + IDX_W'(1) : n - IDX_W'(1);
   endfunction

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] node_ff, node_in;
   logic [VAL_W-1:0] span_ff, span_in;
   logic [VAL_W-1:0] blk_ff, blk_in;
   logic [VAL_W-1:0] cur_ff, cur_in;
   logic [VAL_W-1:0] lv_ff, lv_in;
   logic [OFF_W-1:0] off_ff, off_in;
   logic             mode_ff, mode_in;
   bpa_pkg::rsp_type res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   bpa_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [VAL_W-1:0] tree_mem [TREE_N];
   logic [VAL_W-1:0] rd_ff;
   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   logic [VAL_W-1:0] mem_wr_data;
   logic [IDX_W-1:0] mem_rd_addr;

   logic [PG_W-1:0]  want;
   logic [PG_W:0]    blk_round;
   logic             want_big;
   logic             off_big;
   logic [IDX_W-1:0] leaf_node;
   logic [IDX_W:0]   clr_n1;
   logic [IDX_W:0]   clr_n2;
   logic             clr_next_lvl;
   logic [IDX_W-1:0] node_l;
   logic [IDX_W-1:0] node_r;
   logic             pick_r_base;
   logic [VAL_W-1:0] pick_val;
   logic             pick_r;
   logic [IDX_W-1:0] pick_node;
   logic [IDX_W-1:0] pick_l;
   logic [VAL_W-1:0] span_half;
   logic [VAL_W-1:0] span2;
   logic [IDX_W-1:0] parent_n;
   logic [IDX_W-1:0] sib_node;
   logic [IDX_W-1:0] sib_parent;
   logic [VAL_W:0]   pair_sum;
   logic [VAL_W-1:0] pair_max;
   logic [VAL_W-1:0] merged;
   logic             aligned;

   assign want      = (req_data.req_pages == '0) ? PG_W'(1) : req_data.req_pages;
   assign blk_round = round_pow2(want);
   assign want_big  = CMP_W'(want) > CMP_W'(POOL);
   assign off_big   = CMP_W'(req_data.free_offset) >= CMP_W'(POOL);
   assign leaf_node = IDX_W'(req_data.free_offset) + IDX_W'(POOL - 1);

   assign clr_n1       = {1'b0, node_ff} + (IDX_W + 1)'(1);
   assign clr_n2       = clr_n1 + (IDX_W + 1)'(1);
   assign clr_next_lvl = (clr_n1 & clr_n2) == '0;

   // The descent takes the child with the smaller value that still fits, left on a tie.
   assign node_l      = {node_ff[IDX_W-2:0], 1'b1};
   assign node_r      = node_l + IDX_W'(1);
   assign pick_r_base = !(lv_ff <= rd_ff);
   assign pick_val    = pick_r_base ? rd_ff : lv_ff;
   assign pick_r      = (blk_ff > pick_val) ? !pick_r_base : pick_r_base;
   assign pick_node   = pick_r ? node_r : node_l;
   assign pick_l      = {pick_node[IDX_W-2:0], 1'b1};
   assign span_half   = span_ff >> 1;
   assign span2       = span_ff << 1;

   assign parent_n   = (node_ff - IDX_W'(1)) >> 1;
   assign sib_node   = sibling(node_ff);
   assign sib_parent = sibling(parent_n);

   // Shared update unit: a parent takes the larger child value, or its full size
   // when a free finds both children fully free.
   assign pair_sum = {1'b0, cur_ff} + {1'b0, rd_ff};
   assign pair_max = (cur_ff > rd_ff) ? cur_ff : rd_ff;
   assign merged   = ((mode_ff == bpa_pkg::FUNC_FREE) && (pair_sum == {1'b0, span2}))
                     ? span2 : pair_max;

   assign aligned = (off_ff & OFF_W'(span_ff - VAL_W'(1))) == '0;

   always_comb begin
      state_in     = state_ff;
      node_in      = node_ff;
      span_in      = span_ff;
      blk_in       = blk_ff;
      cur_in       = cur_ff;
      lv_in        = lv_ff;
      off_in       = off_ff;
      mode_in      = mode_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = node_ff;
      mem_wr_data  = span_ff;
      mem_rd_addr  = '0;
      req_ready    = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_wr_en = 1'b1;
            node_in   = node_ff + IDX_W'(1);
            if (clr_next_lvl) begin
               span_in = span_half;
            end
            if (node_ff == IDX_W'(TREE_N - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mode_in = req_data.func;
               res_in.page_offset = '0;
               if (req_data.func == bpa_pkg::FUNC_ALLOC) begin
                  if (want_big) begin
                     res_in.status = bpa_pkg::STATUS_NO_SPACE;
                     state_in      = S_DONE;
                  end else begin
                     blk_in   = VAL_W'(blk_round);
                     state_in = S_ROOT;
                  end
               end else begin
                  if (off_big) begin
                     res_in.status = bpa_pkg::STATUS_BAD_FREE;
                     state_in      = S_DONE;
                  end else begin
                     node_in     = leaf_node;
                     mem_rd_addr = leaf_node;
                     span_in     = VAL_W'(1);
                     off_in      = OFF_W'(req_data.free_offset);
                     state_in    = S_CLIMB;
                  end
               end
            end
         end
         S_ROOT: begin
            if (blk_ff > rd_ff) begin
               res_in.status = bpa_pkg::STATUS_NO_SPACE;
               state_in      = S_DONE;
            end else begin
               node_in = '0;
               span_in = VAL_W'(POOL);
               off_in  = '0;
               if (VAL_W'(POOL) > blk_ff) begin
                  mem_rd_addr = IDX_W'(1);
                  state_in    = S_RIGHT;
               end else begin
                  state_in = S_MARK;
               end
            end
         end
         S_RIGHT: begin
            mem_rd_addr = node_r;
            lv_in       = rd_ff;
            state_in    = S_PICK;
         end
         S_PICK: begin
            node_in = pick_node;
            span_in = span_half;
            if (pick_r) begin
               off_in = off_ff + OFF_W'(span_half);
            end
            if (span_half > blk_ff) begin
               mem_rd_addr = pick_l;
               state_in    = S_RIGHT;
            end else begin
               state_in = S_MARK;
            end
         end
         S_MARK: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = '0;
            cur_in      = '0;
            if (node_ff == '0) begin
               res_in.status      = bpa_pkg::STATUS_OK;
               res_in.page_offset = PO_W'(off_ff);
               state_in           = S_DONE;
            end else begin
               mem_rd_addr = sib_node;
               state_in    = S_UP;
            end
         end
         S_CLIMB: begin
            if (rd_ff == '0) begin
               if (aligned) begin
                  mem_wr_en = 1'b1;
                  cur_in    = span_ff;
                  if (node_ff == '0) begin
                     res_in.status = bpa_pkg::STATUS_OK;
                     state_in      = S_DONE;
                  end else begin
                     mem_rd_addr = sib_node;
                     state_in    = S_UP;
                  end
               end else begin
                  res_in.status = bpa_pkg::STATUS_BAD_FREE;
                  state_in      = S_DONE;
               end
            end else if (node_ff == '0) begin
               res_in.status = bpa_pkg::STATUS_BAD_FREE;
               state_in      = S_DONE;
            end else begin
               node_in     = parent_n;
               span_in     = span2;
               mem_rd_addr = parent_n;
            end
         end
         S_UP: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = parent_n;
            mem_wr_data = merged;
            node_in     = parent_n;
            cur_in      = merged;
            span_in     = span2;
            if (parent_n == '0) begin
               res_in.status      = bpa_pkg::STATUS_OK;
               res_in.page_offset = (mode_ff == bpa_pkg::FUNC_ALLOC) ? PO_W'(off_ff) : '0;
               state_in           = S_DONE;
            end else begin
               mem_rd_addr = sib_parent;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         node_ff      <= '0;
         span_ff      <= VAL_W'(POOL);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         node_ff      <= node_in;
         span_ff      <= span_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff      <= blk_in;
      cur_ff      <= cur_in;
      lv_ff       <= lv_in;
      off_ff      <= off_in;
      mode_ff     <= mode_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         tree_mem[mem_wr_addr] <= mem_wr_data;
      end
      rd_ff <= tree_mem[mem_rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/bpa_checker.sv
`include "buddy_page_allocator_assert.svh"

module bpa_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bpa_pkg::rsp_type rsp_data
);

   logic status_known;
   logic rsp_failed;

   assign status_known = rsp_data.status == bpa_pkg::STATUS_OK ||
                         rsp_data.status == bpa_pkg::STATUS_NO_SPACE ||
                         rsp_data.status == bpa_pkg::STATUS_BAD_FREE;
   assign rsp_failed   = rsp_valid && rsp_data.status != bpa_pkg::STATUS_OK;

   `BPA_ASSERT_SAME(a_status_code, rsp_valid, status_known)
   `BPA_ASSERT_SAME(a_offset_zero, rsp_failed, rsp_data.page_offset == '0)
   `BPA_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)
   `BPA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `BPA_ASSERT_AFTER_RESET(a_clear_pass, reset, !req_ready && !rsp_valid)

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (.*);
